@@ rtl/vpmt_pkg.sv @@
package vpmt_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ADDR_W = 64;

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_PHYS_OF_V = 2'd1;
  localparam logic [1:0] OP_VIRT_OF_P = 2'd2;
  localparam logic [1:0] OP_SIZE_OF_V = 2'd3;

  typedef struct packed {
    logic load;
    logic inc_idx;
    logic set_hit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic idx_last;
    logic match;
  } dp_stat_t;

endpackage

@@ rtl/vpmt_ram.sv @@
module vpmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/vpmt_dp.sv @@
module vpmt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  vpmt_pkg::dp_cmd_t           cmd,
  output vpmt_pkg::dp_stat_t          stat,
  input  logic [1:0]                  operation,
  input  logic [vpmt_pkg::ADDR_W-1:0] virt_addr,
  input  logic [vpmt_pkg::ADDR_W-1:0] phys_addr,
  input  logic [vpmt_pkg::ADDR_W-1:0] region_bytes,
  output logic [vpmt_pkg::ADDR_W-1:0] result_value,
  output logic                        found,
  output logic                        table_full,
  output logic                        done
);
  import vpmt_pkg::*;

  logic [1:0]        op;
  logic [ADDR_W-1:0] va, pa, len;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic              hit;
  logic [ADDR_W-1:0] v_rd, p_rd, l_rd;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              count_full;
  logic [ADDR_W-1:0] sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      va  <= virt_addr;
      pa  <= phys_addr;
      len <= region_bytes;
    end
  end

  assign count_full = (count == CNT_W'(SLOTS));

  // insert reuses the zero slot it hit, otherwise appends at the count unless the table is full
  assign we    = cmd.finish && (op == OP_INSERT) && (hit || !count_full);
  assign waddr = hit ? idx : count[IDX_W-1:0];

  vpmt_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_virt (
    .clk(clk), .we(we), .waddr(waddr), .wdata(va), .raddr(idx), .rdata(v_rd)
  );
  vpmt_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_phys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pa), .raddr(idx), .rdata(p_rd)
  );
  vpmt_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_len (
    .clk(clk), .we(we), .waddr(waddr), .wdata(len), .raddr(idx), .rdata(l_rd)
  );

  always_comb begin
    stat.count_zero = (count == '0);
    stat.idx_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);
    case (op)
      OP_INSERT:    stat.match = (v_rd == '0);
      OP_VIRT_OF_P: stat.match = (p_rd == pa);
      default:      stat.match = (v_rd == va);
    endcase
    case (op)
      OP_PHYS_OF_V: sel = p_rd;
      OP_VIRT_OF_P: sel = v_rd;
      OP_SIZE_OF_V: sel = l_rd;
      default:      sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
      hit   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        idx <= '0;
        hit <= 1'b0;
      end else if (cmd.inc_idx) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.set_hit) begin
        hit <= 1'b1;
      end
      if (we && !hit) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // read data still holds the slot at idx while finishing
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op == OP_INSERT) begin
        result_value <= '0;
        found        <= hit || !count_full;
        table_full   <= !hit && count_full;
      end else begin
        result_value <= hit ? sel : '0;
        found        <= hit;
        table_full   <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS)) else $error("used count past table size");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && table_full)) else $error("found and table_full together");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> result_value == '0) else $error("miss with nonzero value");
  a_lookup_not_full: assert property (@(posedge clk) disable iff (rst)
    done && (op != OP_INSERT) |-> !table_full) else $error("lookup flagged full");

endmodule

@@ rtl/vpmt_ctrl.sv @@
module vpmt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output vpmt_pkg::dp_cmd_t  cmd,
  input  vpmt_pkg::dp_stat_t stat
);
  import vpmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.count_zero ? S_FIN : S_READ;
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (stat.match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_FIN;
        end else if (stat.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_READ;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> state == S_IDLE) else $error("finish not followed by idle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request taken but not busy");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.inc_idx, cmd.set_hit, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

@@ rtl/virt_phys_mapping_table.sv @@
// mapping table of up to SLOTS regions (virtual, physical, size) in three
// 64-bit rams; raise start while busy is low to issue a request, and exactly
// one result comes back on result_value/found/table_full with done high for a
// single cycle, which the receiver must take then. the table is scanned one
// used slot at a time (ram read, then compare), visiting at most the used
// count of slots, and none while the table is empty. lookups answer from the
// lowest matching slot; insert reuses the first slot with a zero virtual
// address or appends, and reports table_full when it drops
module virt_phys_mapping_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic [vpmt_pkg::ADDR_W-1:0] virt_addr,
  input  logic [vpmt_pkg::ADDR_W-1:0] phys_addr,
  input  logic [vpmt_pkg::ADDR_W-1:0] region_bytes,
  output logic [vpmt_pkg::ADDR_W-1:0] result_value,
  output logic                        found,
  output logic                        table_full,
  output logic                        done
);
  import vpmt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vpmt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  vpmt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .operation(operation), .virt_addr(virt_addr), .phys_addr(phys_addr),
    .region_bytes(region_bytes), .result_value(result_value), .found(found),
    .table_full(table_full), .done(done)
  );

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vpmt_pkg::*;

  localparam int RAND_ITEMS = 1900;
  // two copies of the table: one scores the dut, one steers stimulus generation
  localparam int CHECK = 0;
  localparam int PLAN  = 1;
  localparam int TAIL_CYCLES = 2 * SLOTS + 20;

  typedef struct {
    logic [1:0]        op;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] len;
    int                idle_pct;
    bit                drain;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] value;
    logic              hit;
    logic              full;
  } lookup_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        operation = OP_INSERT;
  logic [ADDR_W-1:0] virt_addr = '0;
  logic [ADDR_W-1:0] phys_addr = '0;
  logic [ADDR_W-1:0] region_bytes = '0;
  logic              busy;
  logic [ADDR_W-1:0] result_value;
  logic              found;
  logic              table_full;
  logic              done;

  logic [ADDR_W-1:0] tbl_virt [2][SLOTS];
  logic [ADDR_W-1:0] tbl_phys [2][SLOTS];
  logic [ADDR_W-1:0] tbl_len  [2][SLOTS];
  int                tbl_count [2] = '{0, 0};

  request_t pending[$];
  lookup_t  expected_q[$];
  request_t cur_req;
  int       accepted_cnt = 0;
  int       rcvd = 0;
  int       errors = 0;

  virt_phys_mapping_table dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .virt_addr    (virt_addr),
    .phys_addr    (phys_addr),
    .region_bytes (region_bytes),
    .result_value (result_value),
    .found        (found),
    .table_full   (table_full),
    .done         (done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to table copy m and return what it answers
  function automatic lookup_t map_request(input int m, input request_t r);
    lookup_t res;
    int      lim;
    int      i;
    bit      stored;
    bit      match;
    res.value = '0;
    res.hit = 1'b0;
    res.full = 1'b0;
    lim = tbl_count[m];
    if (r.op == OP_INSERT) begin
      stored = 1'b0;
      for (i = 0; i < lim && !stored; i++) begin
        if (tbl_virt[m][i] == '0) begin
          tbl_virt[m][i] = r.va;
          tbl_phys[m][i] = r.pa;
          tbl_len[m][i] = r.len;
          stored = 1'b1;
        end
      end
      if (!stored && lim < SLOTS) begin
        tbl_virt[m][lim] = r.va;
        tbl_phys[m][lim] = r.pa;
        tbl_len[m][lim] = r.len;
        tbl_count[m] = lim + 1;
        stored = 1'b1;
      end
      res.hit = stored;
      res.full = !stored;
    end else begin
      for (i = 0; i < lim && !res.hit; i++) begin
        if (r.op == OP_VIRT_OF_P) match = (tbl_phys[m][i] == r.pa);
        else match = (tbl_virt[m][i] == r.va);
        if (match) begin
          res.hit = 1'b1;
          case (r.op)
            OP_PHYS_OF_V: res.value = tbl_phys[m][i];
            OP_VIRT_OF_P: res.value = tbl_virt[m][i];
            default:      res.value = tbl_len[m][i];
          endcase
        end
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return ADDR_W'($urandom_range(15));
      3: return ADDR_W'(1) << $urandom_range(ADDR_W - 1);
      default: return rand_word();
    endcase
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [ADDR_W-1:0] va,
                               input logic [ADDR_W-1:0] pa, input logic [ADDR_W-1:0] len,
                               input int idle_pct, input bit drain);
    request_t r;
    r.op = op;
    r.va = va;
    r.pa = pa;
    r.len = len;
    r.idle_pct = idle_pct;
    r.drain = drain;
    void'(map_request(PLAN, r));
    pending.push_back(r);
  endtask

  initial begin
    logic [1:0]        op;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] len;
    int                idle;
    int                k;
    int                j;
    int                cnt;
    bit                has_zero;

    // empty table: every lookup misses
    queue_request(OP_PHYS_OF_V, '0, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_VIRT_OF_P, rand_word(), '1, rand_word(), 0, 1'b0);
    queue_request(OP_SIZE_OF_V, '1, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_INSERT, '1, '0, '1, 0, 1'b0);
    // zero virtual address is stored, then counts as a free slot
    queue_request(OP_INSERT, '0, '1, '0, 0, 1'b0);
    // duplicate virtual key, lookups must answer from the lower slot
    queue_request(OP_INSERT, '1, 64'h1234, 64'h40, 0, 1'b0);
    queue_request(OP_PHYS_OF_V, '1, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_SIZE_OF_V, '1, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_VIRT_OF_P, rand_word(), '0, rand_word(), 0, 1'b0);
    queue_request(OP_VIRT_OF_P, rand_word(), '1, rand_word(), 0, 1'b0);
    queue_request(OP_PHYS_OF_V, '0, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_SIZE_OF_V, '0, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_VIRT_OF_P, rand_word(), 64'h1234, rand_word(), 0, 1'b0);
    queue_request(OP_PHYS_OF_V, 64'h5, rand_word(), rand_word(), 0, 1'b0);
    // appends: the zero-address slot was already reused by the duplicate insert
    queue_request(OP_INSERT, 64'h5, 64'h6, 64'h7, 0, 1'b1);
    queue_request(OP_PHYS_OF_V, '0, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_VIRT_OF_P, rand_word(), '1, rand_word(), 0, 1'b0);
    queue_request(OP_PHYS_OF_V, 64'h5, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_SIZE_OF_V, 64'h5, rand_word(), rand_word(), 0, 1'b0);
    queue_request(OP_INSERT, 64'h8000_0000_0000_0000, '1, 64'h1, 0, 1'b0);

    for (k = 0; k < RAND_ITEMS; k++) begin
      idle = (k < RAND_ITEMS / 3) ? 31 : (k < 2 * RAND_ITEMS / 3) ? 75 : 0;
      cnt = tbl_count[PLAN];
      len = pick_word();
      // inserts stay rare until late, then the table fills and drops show up
      if ($urandom_range(99) < ((k < 1250) ? 6 : 30)) begin
        op = OP_INSERT;
        has_zero = 1'b0;
        for (j = 0; j < cnt; j++) if (tbl_virt[PLAN][j] == '0) has_zero = 1'b1;
        case ($urandom_range(9))
          0: va = '0;
          1: va = (cnt > 0) ? tbl_virt[PLAN][$urandom_range(cnt - 1)] : rand_word();
          2, 3: va = ADDR_W'($urandom_range(15));
          default: va = rand_word();
        endcase
        // last free slot gets a zero address so a full table can still reuse it
        if (cnt == SLOTS - 1 && !has_zero) va = '0;
        case ($urandom_range(4))
          0: pa = (cnt > 0) ? tbl_phys[PLAN][$urandom_range(cnt - 1)] : rand_word();
          1: pa = ADDR_W'($urandom_range(15));
          default: pa = pick_word();
        endcase
      end else begin
        case ($urandom_range(2))
          0: op = OP_PHYS_OF_V;
          1: op = OP_VIRT_OF_P;
          default: op = OP_SIZE_OF_V;
        endcase
        if (cnt > 0 && $urandom_range(99) < 70) begin
          j = $urandom_range(cnt - 1);
          va = tbl_virt[PLAN][j];
          pa = tbl_phys[PLAN][j];
        end else begin
          va = pick_word();
          pa = pick_word();
        end
      end
      queue_request(op, va, pa, len, idle, (k % 300) == 299);
    end
  end

  // driver
  always @(posedge clk) begin
    request_t nxt;
    bit       take_next;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take_next = 1'b0;
      if (start && !busy) begin
        expected_q.push_back(map_request(CHECK, cur_req));
        accepted_cnt++;
        take_next = 1'b1;
      end else if (!start) begin
        take_next = 1'b1;
      end
      if (take_next) begin
        // rcvd is updated with a nonblocking write, so done tells what lands this edge
        if (pending.size() == 0) begin
          start <= 1'b0;
        end else if (pending[0].drain && accepted_cnt != rcvd + int'(done)) begin
          start <= 1'b0;
        end else if ($urandom_range(99) < pending[0].idle_pct) begin
          start <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          cur_req = nxt;
          start <= 1'b1;
          operation <= nxt.op;
          virt_addr <= nxt.va;
          phys_addr <= nxt.pa;
          region_bytes <= nxt.len;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && done) begin
      rcvd <= rcvd + 1;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h found %b table_full %b", $time,
                 result_value, found, table_full);
      end else begin
        want = expected_q.pop_front();
        if (result_value !== want.value) begin
          errors++;
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   result_value);
        end
        if (found !== want.hit) begin
          errors++;
          $display("%0t: found expected %b actual %b", $time, want.hit, found);
        end
        if (table_full !== want.full) begin
          errors++;
          $display("%0t: table_full expected %b actual %b", $time, want.full, table_full);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending.size() != 0 || start || accepted_cnt != rcvd) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/vpmt_pkg.sv
rtl/vpmt_ram.sv
rtl/vpmt_dp.sv
rtl/vpmt_ctrl.sv
rtl/virt_phys_mapping_table.sv
tb/tb.sv
